>>> rtl/lcrs_pkg.sv
// shared types and constants for the line camera readout sequencer
package lcrs_pkg;

    localparam int unsigned PIXELS      = 128;
    localparam int unsigned END_WAIT    = 8;
    localparam int unsigned CNT_W       = 11;
    localparam int unsigned WAIT_W      = 8;
    localparam int unsigned ADDR_W      = 7;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned NUM_SAMPLES = 8;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned OUT_DATA_W  = 48;
    localparam int unsigned OUT_USER_W  = 2;

    localparam logic [CNT_W-1:0]  PIXELS_CNT   = CNT_W'(PIXELS);
    localparam logic [WAIT_W-1:0] END_WAIT_CNT = WAIT_W'(END_WAIT);

    localparam logic [MODE_W-1:0] MODE_BOTH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SECOND = 2'd2;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ADC  = 1'b1;

    typedef logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] sample_vec_t;

    typedef struct packed {
        logic              si;
        logic              clk;
        logic              start_adc;
        logic [ADDR_W-1:0] pixel_addr;
    } seq_status_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] first_value;
        logic                first_write;
        logic [SAMPLE_W-1:0] second_value;
        logic                second_write;
    } avg_result_t;

endpackage

>>> rtl/lcrs_seq.sv
// sensor pulse sequencer: si and clock levels, pixel counter, end wait
module lcrs_seq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 is_tick,
    output lcrs_pkg::seq_status_t status
);

    typedef enum logic [3:0] {
        PH_START        = 4'd0,
        PH_FIRST_CLK_HI = 4'd1,
        PH_SI_LO        = 4'd2,
        PH_FIRST_CLK_LO = 4'd3,
        PH_WAIT_A       = 4'd4,
        PH_WAIT_B       = 4'd5,
        PH_CLK_HI       = 4'd6,
        PH_CLK_LO       = 4'd7,
        PH_END_WAIT     = 4'd8
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic [lcrs_pkg::CNT_W-1:0]     pixel_cnt_reg, pixel_cnt_next, pixel_cnt_inc;
    logic [lcrs_pkg::WAIT_W-1:0]    wait_cnt_reg, wait_cnt_next, wait_cnt_inc;
    logic                           si_reg, si_next;
    logic                           clk_lvl_reg, clk_lvl_next;
    logic                           adc_pulse;

    assign pixel_cnt_inc = pixel_cnt_reg + lcrs_pkg::CNT_W'(1);
    assign wait_cnt_inc  = wait_cnt_reg + lcrs_pkg::WAIT_W'(1);

    always_comb
    begin
        phase_next     = phase_reg;
        pixel_cnt_next = pixel_cnt_reg;
        wait_cnt_next  = wait_cnt_reg;
        si_next        = si_reg;
        clk_lvl_next   = clk_lvl_reg;
        adc_pulse      = 1'b0;
        unique case (phase_reg)
            PH_FIRST_CLK_HI:
            begin
                clk_lvl_next = 1'b1;
                phase_next   = PH_SI_LO;
            end
            PH_SI_LO:
            begin
                si_next    = 1'b0;
                phase_next = PH_FIRST_CLK_LO;
            end
            PH_FIRST_CLK_LO:
            begin
                clk_lvl_next   = 1'b0;
                pixel_cnt_next = '1;
                wait_cnt_next  = '0;
                phase_next     = PH_WAIT_A;
            end
            PH_WAIT_A:
            begin
                phase_next = PH_WAIT_B;
            end
            PH_WAIT_B:
            begin
                phase_next = PH_CLK_HI;
            end
            PH_CLK_HI:
            begin
                pixel_cnt_next = pixel_cnt_inc;
                if (pixel_cnt_inc == lcrs_pkg::PIXELS_CNT)
                begin
                    // last pixel: the clock stays low and the end wait follows
                    clk_lvl_next = 1'b0;
                    phase_next   = PH_END_WAIT;
                end
                else
                begin
                    clk_lvl_next = 1'b1;
                    phase_next   = PH_CLK_LO;
                end
            end
            PH_CLK_LO:
            begin
                adc_pulse    = 1'b1;
                clk_lvl_next = 1'b0;
                phase_next   = PH_CLK_HI;
            end
            PH_END_WAIT:
            begin
                if (wait_cnt_inc >= lcrs_pkg::END_WAIT_CNT)
                begin
                    wait_cnt_next = '0;
                    phase_next    = PH_START;
                end
                else
                begin
                    wait_cnt_next = wait_cnt_inc;
                end
            end
            default:
            begin
                si_next    = 1'b1;
                phase_next = PH_FIRST_CLK_HI;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            pixel_cnt_reg <= '0;
            wait_cnt_reg  <= '0;
            si_reg        <= 1'b0;
            clk_lvl_reg   <= 1'b0;
        end
        else if (step && is_tick)
        begin
            phase_reg     <= phase_next;
            pixel_cnt_reg <= pixel_cnt_next;
            wait_cnt_reg  <= wait_cnt_next;
            si_reg        <= si_next;
            clk_lvl_reg   <= clk_lvl_next;
        end
    end

    // a tick reports the levels after it, a converter word the levels as they stand
    always_comb
    begin
        status.si         = is_tick ? si_next : si_reg;
        status.clk        = is_tick ? clk_lvl_next : clk_lvl_reg;
        status.start_adc  = is_tick & adc_pulse;
        status.pixel_addr = is_tick ? '0 : pixel_cnt_reg[lcrs_pkg::ADDR_W-1:0];
    end

endmodule

>>> rtl/lcrs_avg.sv
// averaging of the eight converter samples per sensor mode
module lcrs_avg
(
    input  lcrs_pkg::sample_vec_t          samples,
    input  logic [lcrs_pkg::MODE_W-1:0]    mode,
    input  logic                           enable,
    output lcrs_pkg::avg_result_t          result
);

    localparam int unsigned SUM4_W = lcrs_pkg::SAMPLE_W + 2;
    localparam int unsigned SUM8_W = lcrs_pkg::SAMPLE_W + 3;

    logic [SUM4_W-1:0] sum_lo;
    logic [SUM4_W-1:0] sum_hi;
    logic [SUM8_W-1:0] sum_all;

    assign sum_lo  = SUM4_W'(samples[0]) + SUM4_W'(samples[1])
                   + SUM4_W'(samples[2]) + SUM4_W'(samples[3]);
    assign sum_hi  = SUM4_W'(samples[4]) + SUM4_W'(samples[5])
                   + SUM4_W'(samples[6]) + SUM4_W'(samples[7]);
    assign sum_all = SUM8_W'(sum_lo) + SUM8_W'(sum_hi);

    always_comb
    begin
        result = '0;
        if (enable)
        begin
            unique case (mode)
                lcrs_pkg::MODE_BOTH:
                begin
                    result.first_value  = sum_lo[SUM4_W-1:2];
                    result.first_write  = 1'b1;
                    result.second_value = sum_hi[SUM4_W-1:2];
                    result.second_write = 1'b1;
                end
                lcrs_pkg::MODE_FIRST:
                begin
                    result.first_value = sum_all[SUM8_W-1:3];
                    result.first_write = 1'b1;
                end
                lcrs_pkg::MODE_SECOND:
                begin
                    result.second_value = sum_all[SUM8_W-1:3];
                    result.second_write = 1'b1;
                end
                default:
                begin
                    result = '0;
                end
            endcase
        end
    end

endmodule

>>> rtl/line_camera_readout_sequencer.sv
// top level of the line camera readout sequencer
//
// channel   direction  handshake               payload
// s_axis    in         tvalid / tready         tuser opcode, tdata samples 0..7
// m_axis    out        tvalid / tready         tdata levels, pixel, values; tuser strobes
// cfg       in         cfg_valid / cfg_ready   cfg_data sensor mode
//
// one word per cycle while m_axis is not stalled; a word is registered first in
// the input register and then in the result register, which offers it on m_axis
// the sequencer state and the sample adders sit between those registers
// rst_n clears the sequencer to its start phase and the mode to both sensors
// a stalled result register holds the input register, which then drops s_axis_tready
module line_camera_readout_sequencer
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample_0 .. sample_7, 16 bits each
    input  logic [lcrs_pkg::NUM_SAMPLES*lcrs_pkg::SAMPLE_W-1:0] s_axis_tdata,
    // opcode
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // si_out, clk_out, start_adc, pixel_addr, first_value, second_value, zero pad
    output logic [lcrs_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // first_write, second_write
    output logic [lcrs_pkg::OUT_USER_W-1:0]       m_axis_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lcrs_pkg::MODE_W-1:0]           cfg_data
);

    logic                              in_valid_reg;
    logic                              opcode_reg;
    lcrs_pkg::sample_vec_t             samples_reg;
    logic [lcrs_pkg::MODE_W-1:0]       mode_reg;
    logic                              out_valid_reg;
    lcrs_pkg::seq_status_t             status_reg;
    lcrs_pkg::avg_result_t             avg_reg;

    logic                              advance;
    logic                              is_tick;
    lcrs_pkg::seq_status_t             status;
    lcrs_pkg::avg_result_t             avg;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;
    assign is_tick       = (opcode_reg == lcrs_pkg::OP_TICK);

    lcrs_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .is_tick (is_tick),
        .status  (status)
    );

    lcrs_avg u_avg
    (
        .samples (samples_reg),
        .mode    (mode_reg),
        .enable  (!is_tick),
        .result  (avg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= lcrs_pkg::MODE_BOTH;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            opcode_reg  <= s_axis_tuser;
            samples_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            status_reg <= status;
            avg_reg    <= avg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, avg_reg.second_value, avg_reg.first_value,
                            status_reg.pixel_addr, status_reg.start_adc,
                            status_reg.clk, status_reg.si};
    assign m_axis_tuser  = {avg_reg.second_write, avg_reg.first_write};

`ifndef SYNTHESIS
    a_adc_clock_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg.start_adc |-> !status_reg.clk)
        else $error("start_adc with clock high");

    a_adc_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg.start_adc |-> !avg_reg.first_write && !avg_reg.second_write)
        else $error("start_adc together with a store strobe");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(opcode_reg))
        else $error("input register lost a word while stalled");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not filled after advance");

    a_strobes_match_mode: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !is_tick && mode_reg == lcrs_pkg::MODE_BOTH
        |=> avg_reg.first_write && avg_reg.second_write)
        else $error("both-sensor mode missing a store strobe");
`endif

endmodule
